FILE: sv/srcs_pkg.sv
// srcs_pkg: shared types, constants and a decode function for the small core step block
// no dependencies
package srcs_pkg;

  localparam int MEM_BYTES_DEF = 4096;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_STOP   = 3'd1;
  localparam logic [2:0] ST_DECERR = 3'd2;
  localparam logic [2:0] ST_UNIMP  = 3'd3;
  localparam logic [2:0] ST_HALTED = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [4:0] {
    K_NONE, K_ADD, K_ADD3, K_BEQ, K_CMP, K_LD, K_LDR, K_LDB, K_MUL, K_MV, K_SLL,
    K_SLL3, K_SLLI, K_ST, K_STR, K_STB, K_UNIMP, K_BC, K_BC24, K_BL, K_BRA, K_JMP,
    K_TRAP, K_ADDI, K_LD24, K_LDI, K_LDI16, K_NOP, K_ERR
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_MUL, S_MEM0, S_MEM1, S_MEM2, S_MEM3,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [0:0]  operation;
    logic [11:0] address;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] instr_pc;
    logic [15:0] instr_high;
    logic [15:0] instr_low;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        cond_bit;
    logic        trace_on;
    logic [3:0]  trap_code;
  } out_word_t;

  function automatic kind_t decode(input logic [15:0] h);
    kind_t k;
    k = K_ERR;
    case (h & 16'hf0f0)
      16'h00a0: k = K_ADD;
      16'h80a0: k = K_ADD3;
      16'hb000: k = K_BEQ;
      16'h0040: k = K_CMP;
      16'h20c0: k = K_LD;
      16'ha0c0: k = K_LDR;
      16'h2080: k = K_LDB;
      16'h1060: k = K_MUL;
      16'h1080: k = K_MV;
      16'h1040: k = K_SLL;
      16'h90c0: k = K_SLL3;
      16'h5040, 16'h5050: k = K_SLLI;
      16'h2040: k = K_ST;
      16'ha040: k = K_STR;
      16'h2000: k = K_STB;
      16'h00c0, 16'h80c0, 16'hb010, 16'h0050, 16'h9000, 16'h9010,
      16'h20e0, 16'ha080, 16'h20a0, 16'ha0a0, 16'h2090, 16'ha090,
      16'h20b0, 16'ha0b0, 16'h0030, 16'h00b0, 16'h00e0, 16'h80e0,
      16'h9020, 16'h9030, 16'h1020, 16'h90a0, 16'h5020, 16'h5030,
      16'h1000, 16'h9080, 16'h5000, 16'h5010, 16'h2060, 16'h2070,
      16'ha000, 16'h2020, 16'ha020, 16'h0020, 16'h00d0, 16'h80d0: k = K_UNIMP;
      default: begin
        case (h & 16'hff00)
          16'h7c00: k = K_BC;
          16'hfc00: k = K_BC24;
          16'h7e00: k = K_BL;
          16'h7f00: k = K_BRA;
          16'hfe00, 16'h7d00, 16'hfd00, 16'hff00: k = K_UNIMP;
          default: begin
            case (h & 16'hfff0)
              16'h1fc0: k = K_JMP;
              16'h10f0: k = K_TRAP;
              16'hb080, 16'hb0b0, 16'hb0d0, 16'hb0c0, 16'hb0a0,
              16'hb090, 16'h8040, 16'h8050, 16'h1ec0: k = K_UNIMP;
              default: begin
                if ((h & 16'hf000) == 16'h4000) k = K_ADDI;
                else if ((h & 16'hf000) == 16'he000) k = K_LD24;
                else if ((h & 16'hf000) == 16'h6000) k = K_LDI;
                else if ((h & 16'hf0ff) == 16'h90f0) k = K_LDI16;
                else if (h == 16'h7000) k = K_NOP;
                else if ((h & 16'hf0ff) == 16'hd0c0) k = K_UNIMP;
                else k = K_ERR;
              end
            endcase
          end
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

FILE: sv/srcs_if.sv
// srcs_if: valid/ready channel carrying one word of type word_t
// no dependencies
interface srcs_if #(parameter type word_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/srcs_front.sv
// srcs_front: two-entry queue of accepted words
// depends on srcs_pkg
module srcs_front
  import srcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output in_word_t q_data
);
  in_word_t   slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_take && q_valid;
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: sv/srcs_back.sv
// srcs_back: sequencer that executes queued words against byte memory and registers
// depends on srcs_pkg
module srcs_back
  import srcs_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_take,
  input  in_word_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [AW:0] clr_cnt;
  logic        clearing;

  logic [31:0] rf [16];
  logic [31:0] pc;
  logic        cflag;
  logic        tflag;
  logic        halted;

  state_t      state;
  state_t      state_next;
  in_word_t    cur;
  logic [31:0] fa;
  logic [31:0] ir;
  logic [31:0] ma;
  logic [31:0] ld;
  logic [31:0] sd;
  logic [31:0] prod;
  logic [1:0]  cnt;
  kind_t       kind;

  logic [7:0]  rdata;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [7:0]  wdata;

  logic [15:0] h1;
  logic [15:0] h2;
  logic [3:0]  rdi;
  logic [3:0]  rsi;
  logic [31:0] vd;
  logic [31:0] vs;
  logic [31:0] base;
  logic [31:0] s16;
  logic [31:0] s8;
  logic [31:0] lin;
  logic [31:0] eaddr;
  logic        is_mem;
  logic        is_store;

  out_word_t   res;
  logic        wr_reg;
  logic [3:0]  widx;
  logic [31:0] wval;
  logic [31:0] npc;
  logic [2:0]  st;
  logic        cnext;
  logic        tnext;

  assign h1 = ir[31:16];
  assign h2 = h1[15] ? ir[15:0] : 16'h0;
  assign rdi = h1[11:8];
  assign rsi = h1[3:0];
  assign vd = rf[rdi];
  assign vs = rf[rsi];
  assign base = pc & 32'hfffffffc;
  assign s16 = {{16{h2[15]}}, h2};
  assign s8 = {{24{h1[7]}}, h1[7:0]};
  assign lin = h1[15] ? pc + 32'd4 : pc + 32'd2;
  assign eaddr = (kind == K_LDR || kind == K_STR) ? vs + s16 : vs;
  assign is_mem = (kind == K_LD || kind == K_LDR || kind == K_LDB || kind == K_ST
                   || kind == K_STR || kind == K_STB);
  assign is_store = (kind == K_ST || kind == K_STR || kind == K_STB);
  assign clearing = !clr_cnt[AW];

  always_comb begin
    raddr = fa[AW-1:0];
    if (state == S_MEM0 || state == S_MEM1 || state == S_MEM2 || state == S_MEM3) begin
      raddr = ma[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    wr_reg = 1'b0;
    widx = rdi;
    wval = 32'h0;
    npc = lin;
    st = ST_OK;
    cnext = cflag;
    tnext = tflag;
    case (kind)
      K_ADD: begin wr_reg = 1'b1; wval = vd + vs; end
      K_ADD3: begin wr_reg = 1'b1; wval = vs + s16; end
      K_BEQ: if (vd == vs) npc = base + {s16[29:0], 2'b00};
      K_CMP: cnext = ($signed(vd) < $signed(vs));
      K_LD, K_LDR: begin wr_reg = 1'b1; wval = ld; end
      K_LDB: begin wr_reg = 1'b1; wval = {{24{ld[7]}}, ld[7:0]}; end
      K_MUL: begin wr_reg = 1'b1; wval = prod; end
      K_MV: begin wr_reg = 1'b1; wval = vs; end
      K_SLL: begin wr_reg = 1'b1; wval = vd << vs[4:0]; end
      K_SLL3: begin wr_reg = 1'b1; wval = vs << h2[4:0]; end
      K_SLLI: begin wr_reg = 1'b1; wval = vd << h1[4:0]; end
      K_ST, K_STR, K_STB, K_NOP, K_NONE: ;
      K_UNIMP: st = ST_UNIMP;
      K_BC: if (cflag) npc = base + {s8[29:0], 2'b00};
      K_BC24: if (cflag) npc = base + {{6{h1[7]}}, h1[7:0], h2, 2'b00};
      K_BL: begin
        wr_reg = 1'b1;
        widx = 4'd14;
        wval = base + 32'd4;
        npc = base + {s8[29:0], 2'b00};
      end
      K_BRA: npc = base + {s8[29:0], 2'b00};
      K_JMP: npc = vs & 32'hfffffffc;
      K_TRAP: begin
        if (rsi == 4'd0) st = ST_STOP;
        else if (rsi == 4'd1) tnext = 1'b1;
      end
      K_ADDI: begin wr_reg = 1'b1; wval = vd + s8; end
      K_LD24: begin wr_reg = 1'b1; wval = {8'h0, h1[7:0], h2}; end
      K_LDI: begin wr_reg = 1'b1; wval = s8; end
      K_LDI16: begin wr_reg = 1'b1; wval = s16; end
      K_ERR: st = ST_DECERR;
      default: st = ST_DECERR;
    endcase
    if (st == ST_STOP || st == ST_DECERR) npc = pc;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid && !clearing) begin
          if (q_data.operation == OP_WRITE || halted) state_next = S_DONE;
          else state_next = S_F0;
        end
      end
      S_F0: state_next = S_F1;
      S_F1: state_next = S_F2;
      S_F2: state_next = ir[31] ? S_F3 : S_EXEC;
      S_F3: state_next = S_F4;
      S_F4: state_next = S_EXEC;
      S_EXEC: begin
        if (kind == K_MUL) state_next = S_MUL;
        else if (is_mem) state_next = S_MEM0;
        else state_next = S_DONE;
      end
      S_MUL: state_next = S_DONE;
      S_MEM0: begin
        if (kind == K_STB || kind == K_LDB) state_next = (kind == K_LDB) ? S_MEM1 : S_DONE;
        else state_next = S_MEM1;
      end
      S_MEM1: begin
        if (kind == K_LDB) state_next = S_DONE;
        else state_next = S_MEM2;
      end
      S_MEM2: state_next = S_MEM3;
      S_MEM3: state_next = (cnt == 2'd1) ? S_DONE : S_MEM3;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == S_IDLE) && !clearing;
    we = 1'b0;
    waddr = clr_cnt[AW-1:0];
    wdata = 8'h0;
    if (clearing) begin
      we = 1'b1;
    end else if (state == S_IDLE && q_valid && q_data.operation == OP_WRITE) begin
      we = 1'b1;
      waddr = AW'({20'h0, q_data.address});
      wdata = q_data.data_byte;
    end else if (is_store && (state == S_MEM0 || state == S_MEM1 || state == S_MEM2
                 || (state == S_MEM3 && cnt == 2'd0))) begin
      we = 1'b1;
      waddr = ma[AW-1:0];
      wdata = sd[31:24];
    end
  end

  always_comb begin
    res = '0;
    res.instr_pc = pc;
    res.next_pc = pc;
    res.cond_bit = cflag;
    res.trace_on = tflag;
    if (cur.operation == OP_STEP) begin
      if (halted) begin
        res.status = ST_HALTED;
      end else begin
        res.status = st;
        res.instr_high = h1;
        res.instr_low = h2;
        res.next_pc = npc;
        res.reg_written = wr_reg;
        res.reg_index = wr_reg ? widx : 4'd0;
        res.reg_value = wr_reg ? wval : 32'd0;
        res.cond_bit = cnext;
        res.trace_on = tnext;
        res.trap_code = (kind == K_TRAP) ? rsi : 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clr_cnt <= '0;
      pc <= 32'h0;
      cflag <= 1'b0;
      tflag <= 1'b0;
      halted <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) rf[i] <= 32'h0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !clearing) begin
            cur <= q_data;
            fa <= pc;
            ir <= 32'h0;
            kind <= K_NONE;
          end
        end
        S_F0: fa <= fa + 32'd1;
        S_F1: begin ir[31:24] <= rdata; fa <= fa + 32'd1; end
        S_F2: begin
          ir[23:16] <= rdata;
          fa <= fa + 32'd1;
          if (!ir[31]) kind <= decode({ir[31:24], rdata});
        end
        S_F3: begin ir[15:8] <= rdata; fa <= fa + 32'd1; end
        S_F4: begin
          ir[7:0] <= rdata;
          kind <= decode(h1);
        end
        S_EXEC: begin
          prod <= vd * vs;
          ma <= eaddr;
          sd <= (kind == K_STB) ? {vd[7:0], 24'h0} : vd;
          cnt <= 2'd0;
        end
        S_MEM0, S_MEM1, S_MEM2: begin
          ma <= ma + 32'd1;
          sd <= {sd[23:0], 8'h0};
          if (state != S_MEM0) ld <= {ld[23:0], rdata};
        end
        S_MEM3: begin
          ld <= {ld[23:0], rdata};
          cnt <= cnt + 2'd1;
          if (cnt == 2'd0) begin
            ma <= ma + 32'd1;
            sd <= {sd[23:0], 8'h0};
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data <= res;
            if (cur.operation == OP_STEP && !halted) begin
              pc <= npc;
              cflag <= cnext;
              tflag <= tnext;
              if (st == ST_STOP || st == ST_DECERR) halted <= 1'b1;
              if (wr_reg) rf[widx] <= wval;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: sv/sixteen_reg_cpu_step.sv
// sixteen_reg_cpu_step: 32-bit core step with 16 registers and byte memory
// flow: a byte write or a step while halted goes straight to the result register; an
// instruction fetches two or four bytes, executes, then multiply, loads and stores pass further states
// throughput: one word at a time in the back end, and a result waits there while out_ready is low;
// the single byte-wide memory port sets the rate, a two-word queue takes words meanwhile
// reset: registers, pc and flags clear at once; memory is then swept to zero before words are taken
module sixteen_reg_cpu_step
  import srcs_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  srcs_if.sink   in_ch,
  srcs_if.source out_ch
);
  logic     q_valid;
  logic     q_take;
  in_word_t q_data;

  srcs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  srcs_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

FILE: sv/srcs_check.sv
// srcs_check: port-level checks on the core step block, bound to the top level
// depends on srcs_pkg
module srcs_check
  import srcs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_HALTED)
    else $error("bad status");
  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_STOP || out_data.status == ST_HALTED)
    |-> out_data.next_pc == out_data.instr_pc)
    else $error("pc moved on stop");
  a_noreg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reg_written |-> out_data.reg_value == 32'd0)
    else $error("value without write");
endmodule

bind sixteen_reg_cpu_step srcs_check u_check (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
